// File: rtl/core/wsd_pkg.sv
// shared types and constants of the websocket client frame deframer
`timescale 1ns / 1ps

package wsd_pkg;

   // frame opcodes
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   // header bit fields
   localparam logic [7:0] RSV_MASK    = 8'h70;
   localparam logic [6:0] LEN_16_CODE = 7'd126;
   localparam logic [6:0] LEN_64_CODE = 7'd127;
   localparam logic [6:0] MAX_CTRL_LEN = 7'd125;

   // length forms
   localparam logic [1:0] FORM_7  = 2'd0;
   localparam logic [1:0] FORM_16 = 2'd1;
   localparam logic [1:0] FORM_64 = 2'd2;

   // header positions where the extended length ends, per form
   localparam logic [3:0] EXT_END_7  = 4'd2;
   localparam logic [3:0] EXT_END_16 = 4'd4;
   localparam logic [3:0] EXT_END_64 = 4'd10;
   localparam logic [3:0] MASK_BYTES_M1 = 4'd3;

   // close status codes
   localparam logic [15:0] CLOSE_NORMAL   = 16'd1000;
   localparam logic [15:0] CLOSE_PROTOCOL = 16'd1002;
   localparam logic [15:0] CLOSE_DATA     = 16'd1003;

   // wire bytes of generated frames
   localparam logic [7:0] PONG_HDR0  = 8'h8A;
   localparam logic [7:0] CLOSE_HDR0 = 8'h88;
   localparam logic [7:0] CLOSE_HDR1 = 8'h02;

   // destinations
   localparam logic DEST_APP  = 1'b0;
   localparam logic DEST_WIRE = 1'b1;

   // work handed from the parser to the output sequencer
   typedef enum logic [1:0] {
      CMD_BYTE,
      CMD_PONG,
      CMD_CLOSE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         dest;
      logic [15:0]  pl;
   } cmd_type;

endpackage

// File: rtl/core/wsd_front.sv
// frame parser: header decode, unmasking and command generation
`timescale 1ns / 1ps

module wsd_front
   import wsd_pkg::*;
#(
   parameter int LEN_BITS = 63
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_fire,
   input  logic [7:0] in_byte,
   output logic       push,
   output cmd_type    cmd
);

   logic [3:0]          header_pos_ff, header_pos_in;
   logic                in_payload_ff, in_payload_in;
   logic                closed_ff, closed_in;
   logic                fin_ff, fin_in;
   logic [3:0]          opcode_ff, opcode_in;
   logic [1:0]          form_ff, form_in;
   logic [LEN_BITS-1:0] len_ff, len_in;
   logic                ovf_ff, ovf_in;
   logic [31:0]         mask_ff, mask_in;
   logic [1:0]          midx_ff, midx_in;
   logic [1:0]          csat_ff, csat_in;
   logic [15:0]         code_ff, code_in;

   logic [3:0]  ext_end;
   logic [3:0]  pos_inc;
   logic [7:0]  mask_byte;
   logic [7:0]  plain;
   logic        frame_end;
   logic        close_req;
   logic [15:0] close_code;

   // extended length end position for the current form
   always_comb begin
      unique case (form_ff)
         FORM_16: ext_end = EXT_END_16;
         FORM_64: ext_end = EXT_END_64;
         default: ext_end = EXT_END_7;
      endcase
   end

   assign pos_inc = header_pos_ff + 4'd1;

   // mask key byte for this payload position
   always_comb begin
      unique case (midx_ff)
         2'd0: mask_byte = mask_ff[31:24];
         2'd1: mask_byte = mask_ff[23:16];
         2'd2: mask_byte = mask_ff[15:8];
         default: mask_byte = mask_ff[7:0];
      endcase
   end

   assign plain = in_byte ^ mask_byte;

   // parse one byte
   always_comb begin
      header_pos_in = header_pos_ff;
      in_payload_in = in_payload_ff;
      closed_in     = closed_ff;
      fin_in        = fin_ff;
      opcode_in     = opcode_ff;
      form_in       = form_ff;
      len_in        = len_ff;
      ovf_in        = ovf_ff;
      mask_in       = mask_ff;
      midx_in       = midx_ff;
      csat_in       = csat_ff;
      code_in       = code_ff;
      push          = 1'b0;
      cmd           = '{kind: CMD_BYTE, dest: DEST_APP, pl: 16'd0};
      frame_end     = 1'b0;
      close_req     = 1'b0;
      close_code    = CLOSE_PROTOCOL;

      if (in_fire && !closed_ff) begin
         if (!in_payload_ff) begin
            if (header_pos_ff == 4'd0) begin
               if ((in_byte & RSV_MASK) != 8'd0) begin
                  close_req = 1'b1;
               end else begin
                  fin_in        = in_byte[7];
                  opcode_in     = in_byte[3:0];
                  header_pos_in = 4'd1;
               end
            end else if (header_pos_ff == 4'd1) begin
               if (!in_byte[7]) begin
                  close_req = 1'b1;
               end else begin
                  header_pos_in = 4'd2;
                  len_in        = '0;
                  mask_in       = 32'd0;
                  ovf_in        = 1'b0;
                  if (in_byte[6:0] == LEN_16_CODE) begin
                     form_in = FORM_16;
                  end else if (in_byte[6:0] == LEN_64_CODE) begin
                     form_in = FORM_64;
                  end else begin
                     form_in = FORM_7;
                     len_in  = LEN_BITS'(in_byte[6:0]);
                     if (opcode_ff[3] && !fin_ff) begin
                        close_req = 1'b1;
                     end
                  end
               end
            end else if (header_pos_ff < ext_end) begin
               if (form_ff == FORM_64 && header_pos_ff == 4'd2 && in_byte[7]) begin
                  close_req = 1'b1;
               end else begin
                  len_in        = {len_ff[LEN_BITS-9:0], in_byte};
                  ovf_in        = ovf_ff | (len_ff[LEN_BITS-1 -: 8] != 8'd0);
                  header_pos_in = pos_inc;
                  if (pos_inc == ext_end) begin
                     if (opcode_ff[3] &&
                         (!fin_ff || ovf_in || len_in > LEN_BITS'(MAX_CTRL_LEN))) begin
                        close_req = 1'b1;
                     end else if (ovf_in) begin
                        close_req = 1'b1;
                     end
                  end
               end
            end else begin
               mask_in       = {mask_ff[23:0], in_byte};
               header_pos_in = pos_inc;
               if (header_pos_ff == ext_end + MASK_BYTES_M1) begin
                  in_payload_in = 1'b1;
                  midx_in       = 2'd0;
                  csat_in       = 2'd0;
                  if (opcode_ff == OP_PING) begin
                     push = 1'b1;
                     cmd  = '{kind: CMD_PONG, dest: DEST_WIRE, pl: {9'd0, len_ff[6:0]}};
                  end
                  if (len_ff == '0) begin
                     frame_end = 1'b1;
                  end
               end
            end
         end else begin
            // payload byte
            midx_in = midx_ff + 2'd1;
            if (csat_ff != 2'd2) begin
               csat_in = csat_ff + 2'd1;
            end
            if (opcode_ff == OP_CLOSE) begin
               if (csat_ff == 2'd0) begin
                  code_in[15:8] = plain;
               end else if (csat_ff == 2'd1) begin
                  code_in[7:0] = plain;
               end
            end
            if (opcode_ff == OP_CONT || opcode_ff == OP_BINARY) begin
               push = 1'b1;
               cmd  = '{kind: CMD_BYTE, dest: DEST_APP, pl: {8'd0, plain}};
            end else if (opcode_ff == OP_PING) begin
               push = 1'b1;
               cmd  = '{kind: CMD_BYTE, dest: DEST_WIRE, pl: {8'd0, plain}};
            end
            if (len_ff == LEN_BITS'(1)) begin
               frame_end = 1'b1;
            end else begin
               len_in = len_ff - LEN_BITS'(1);
            end
         end

         // end of frame actions
         if (frame_end) begin
            header_pos_in = 4'd0;
            in_payload_in = 1'b0;
            priority if (opcode_ff == OP_CONT || opcode_ff == OP_BINARY ||
                         opcode_ff == OP_PING || opcode_ff == OP_PONG) begin
               close_req = 1'b0;
            end else if (opcode_ff == OP_TEXT) begin
               close_req  = 1'b1;
               close_code = CLOSE_DATA;
            end else if (opcode_ff == OP_CLOSE) begin
               close_req  = 1'b1;
               close_code = (csat_in == 2'd2) ? code_in : CLOSE_NORMAL;
            end else begin
               close_req  = 1'b1;
               close_code = CLOSE_PROTOCOL;
            end
         end

         // close frame goes out once, then silence
         if (close_req) begin
            closed_in = 1'b1;
            push      = 1'b1;
            cmd       = '{kind: CMD_CLOSE, dest: DEST_WIRE, pl: close_code};
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         header_pos_ff <= 4'd0;
         in_payload_ff <= 1'b0;
         closed_ff     <= 1'b0;
         fin_ff        <= 1'b0;
         opcode_ff     <= OP_CONT;
         form_ff       <= FORM_7;
         ovf_ff        <= 1'b0;
         midx_ff       <= 2'd0;
         csat_ff       <= 2'd0;
      end else begin
         header_pos_ff <= header_pos_in;
         in_payload_ff <= in_payload_in;
         closed_ff     <= closed_in;
         fin_ff        <= fin_in;
         opcode_ff     <= opcode_in;
         form_ff       <= form_in;
         ovf_ff        <= ovf_in;
         midx_ff       <= midx_in;
         csat_ff       <= csat_in;
      end
   end

   // frame data registers
   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      mask_ff <= mask_in;
      code_ff <= code_in;
   end

endmodule

// File: rtl/core/wsd_cmd_queue.sv
// short command queue between parser and output sequencer
`timescale 1ns / 1ps

module wsd_cmd_queue
   import wsd_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type         entry_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   assign empty = (count_ff == CW'(0));
   assign full  = (count_ff == CW'(DEPTH));
   assign head  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? PW'(0) : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/core/wsd_back.sv
// output sequencer: expands commands into result bytes
`timescale 1ns / 1ps

module wsd_back
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    head,
   input  logic       empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_dest,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last,
   output logic       rsp_conn_closed
);

   logic [1:0] sub_ff, sub_in;
   logic       valid_ff, valid_in;
   logic       dest_ff;
   logic [7:0] data_ff;
   logic       last_ff;
   logic       cc_ff;

   logic       slot_free;
   logic       emit;
   logic [7:0] out_data;
   logic       out_last;
   logic       out_cc;

   assign slot_free = !valid_ff || !rsp_stall;
   assign emit      = !empty && slot_free;

   // pick the byte for this step of the command
   always_comb begin
      out_data = head.pl[7:0];
      out_last = 1'b1;
      out_cc   = 1'b0;
      unique case (head.kind)
         CMD_BYTE: begin
            out_data = head.pl[7:0];
            out_last = 1'b1;
         end
         CMD_PONG: begin
            out_data = (sub_ff == 2'd0) ? PONG_HDR0 : head.pl[7:0];
            out_last = (sub_ff != 2'd0);
         end
         CMD_CLOSE: begin
            unique case (sub_ff)
               2'd0: out_data = CLOSE_HDR0;
               2'd1: out_data = CLOSE_HDR1;
               2'd2: out_data = head.pl[15:8];
               default: out_data = head.pl[7:0];
            endcase
            out_last = (sub_ff == 2'd3);
            out_cc   = out_last;
         end
         default: begin
            out_data = head.pl[7:0];
            out_last = 1'b1;
         end
      endcase
   end

   assign pop = emit && out_last;

   // step counter and output valid
   always_comb begin
      sub_in   = sub_ff;
      valid_in = valid_ff;
      if (emit) begin
         sub_in   = out_last ? 2'd0 : sub_ff + 2'd1;
         valid_in = 1'b1;
      end else if (slot_free) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         sub_ff   <= sub_in;
         valid_ff <= valid_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (emit) begin
         dest_ff <= head.dest;
         data_ff <= out_data;
         last_ff <= out_last;
         cc_ff   <= out_cc;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_dest        = dest_ff;
   assign rsp_data_byte   = data_ff;
   assign rsp_last        = last_ff;
   assign rsp_conn_closed = cc_ff;

endmodule

// File: rtl/core/websocket_client_frame_deframer_unit.sv
// top level of the websocket client frame deframer
//
//   channel   dir   handshake            payload
//   req       in    req_valid/req_stall  req_rx_byte[7:0]
//   rsp       out   rsp_valid/rsp_stall  rsp_dest, rsp_data_byte[7:0], rsp_last,
//                                        rsp_conn_closed
//
// one request byte is taken per cycle unless req_stall holds it; the parser
// handles it in that cycle. results leave one per cycle through a registered
// output while rsp_stall is low; a ping header yields two results, a close
// frame four, payload bytes one each. a queue of QUEUE_DEPTH commands sits
// between parser and output sequencer; req_stall rises only when it is full.
// synchronous active-high reset clears parser, queue and output control state.
`timescale 1ns / 1ps

module websocket_client_frame_deframer_unit
   import wsd_pkg::*;
#(
   parameter int LEN_BITS    = 63,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_dest,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last,
   output logic       rsp_conn_closed
);

   logic    in_fire;
   logic    push;
   cmd_type push_cmd;
   logic    pop;
   cmd_type head;
   logic    empty;
   logic    full;

   assign req_stall = full;
   assign in_fire   = req_valid && !req_stall;

   // parser
   wsd_front #(
      .LEN_BITS (LEN_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .in_fire (in_fire),
      .in_byte (req_rx_byte),
      .push    (push),
      .cmd     (push_cmd)
   );

   // command queue
   wsd_cmd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full)
   );

   // output sequencer
   wsd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .empty           (empty),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_dest        (rsp_dest),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_last        (rsp_last),
      .rsp_conn_closed (rsp_conn_closed)
   );

endmodule

// File: tb/websocket_client_frame_deframer_unit_tb.sv
// self-checking testbench for the websocket client frame deframer
`timescale 1ns / 1ps

module websocket_client_frame_deframer_unit_tb;
   import wsd_pkg::*;

   // one response as seen on the rsp channel
   typedef struct packed {
      logic       dest;
      logic [7:0] data;
      logic       last;
      logic       closed;
   } deframe_rsp_type;

   // one row of the directed stimulus, with typed-in responses where obvious
   typedef struct packed {
      logic            typed;
      logic [1:0]      cnt;
      logic [7:0]      rx;
      deframe_rsp_type r0;
      deframe_rsp_type r1;
   } stim_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_rx_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_dest;
   logic [7:0] rsp_data_byte;
   logic       rsp_last;
   logic       rsp_conn_closed;

   // run bookkeeping
   bit              quiet = 1'b0;
   int              req_taken = 0;
   int              rsp_checked = 0;
   int              fail_count = 0;
   int              frames_sent = 0;
   deframe_rsp_type pending_out[$];
   deframe_rsp_type got_rsp;
   deframe_rsp_type want_rsp;
   stim_row_type    directed_rows[$];
   stim_row_type    row;

   // row currently on the request port
   logic            cur_typed = 1'b0;
   logic [1:0]      cur_cnt = 2'd0;
   deframe_rsp_type cur_r0 = '0;
   deframe_rsp_type cur_r1 = '0;

   // shadow copy of the parser state
   logic [3:0]      hdr_pos = '0;
   logic            in_pl = 1'b0;
   logic            f_fin = 1'b0;
   logic [3:0]      f_op = '0;
   logic [1:0]      len_form = FORM_7;
   logic [62:0]     pl_len = '0;
   logic [31:0]     key = '0;
   logic [62:0]     pl_cnt = '0;
   logic [15:0]     peer_code = '0;
   logic            conn_done = 1'b0;
   logic [15:0]     close_code_sent = '0;
   deframe_rsp_type step_res[4];
   int              step_cnt = 0;

   websocket_client_frame_deframer_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_dest        (rsp_dest),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_last        (rsp_last),
      .rsp_conn_closed (rsp_conn_closed)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic deframe_rsp_type mk_rsp(logic dest, logic [7:0] data, logic last,
                                              logic cc);
      mk_rsp = {dest, data, last, cc};
   endfunction

   function automatic void emit(logic dest, logic [7:0] data, logic cc);
      step_res[step_cnt] = mk_rsp(dest, data, 1'b0, cc);
      step_cnt++;
   endfunction

   // close frame on the wire, only once per connection
   function automatic void wire_close(logic [15:0] code);
      if (conn_done)
         return;
      conn_done = 1'b1;
      close_code_sent = code;
      emit(DEST_WIRE, CLOSE_HDR0, 1'b0);
      emit(DEST_WIRE, CLOSE_HDR1, 1'b0);
      emit(DEST_WIRE, code[15:8], 1'b0);
      emit(DEST_WIRE, code[7:0], 1'b1);
   endfunction

   // end-of-frame actions per opcode
   function automatic void end_frame();
      logic [3:0] op;
      op = f_op;
      hdr_pos = '0;
      in_pl = 1'b0;
      pl_cnt = '0;
      if (op == OP_CONT || op == OP_BINARY || op == OP_PING || op == OP_PONG)
         return;
      if (op == OP_TEXT)
         wire_close(CLOSE_DATA);
      else if (op == OP_CLOSE)
         wire_close(pl_len >= 2 ? peer_code : CLOSE_NORMAL);
      else
         wire_close(CLOSE_PROTOCOL);
   endfunction

   // control frames must be final and short
   function automatic void check_ctrl_len();
      if (f_op >= OP_CLOSE && (!f_fin || pl_len > MAX_CTRL_LEN))
         wire_close(CLOSE_PROTOCOL);
   endfunction

   // expected responses for one accepted request byte, left in step_res
   function automatic void deframe_byte(logic [7:0] b);
      int         pos;
      int         ext;
      int         k;
      logic [7:0] d;
      step_cnt = 0;
      if (conn_done)
         return;
      if (!in_pl) begin
         pos = hdr_pos;
         ext = (len_form == FORM_7) ? 0 : ((len_form == FORM_16) ? 2 : 8);
         if (pos == 0) begin
            if ((b & RSV_MASK) != 0) begin
               wire_close(CLOSE_PROTOCOL);
            end else begin
               f_fin = b[7];
               f_op = b[3:0];
               hdr_pos = 4'd1;
            end
         end else if (pos == 1) begin
            if (!b[7]) begin
               wire_close(CLOSE_PROTOCOL);
            end else begin
               hdr_pos = 4'd2;
               pl_len = '0;
               key = '0;
               if (b[6:0] == LEN_16_CODE) begin
                  len_form = FORM_16;
               end else if (b[6:0] == LEN_64_CODE) begin
                  len_form = FORM_64;
               end else begin
                  len_form = FORM_7;
                  pl_len = 63'(b[6:0]);
                  check_ctrl_len();
               end
            end
         end else if (pos < 2 + ext) begin
            if (len_form == FORM_64 && pos == 2 && b[7]) begin
               wire_close(CLOSE_PROTOCOL);
            end else begin
               pl_len = {pl_len[54:0], b};
               hdr_pos = 4'(pos + 1);
               if (pos + 1 == 2 + ext)
                  check_ctrl_len();
            end
         end else begin
            key = {key[23:0], b};
            hdr_pos = 4'(pos + 1);
            if (pos + 1 >= 6 + ext) begin
               in_pl = 1'b1;
               pl_cnt = '0;
               if (f_op == OP_PING) begin
                  emit(DEST_WIRE, PONG_HDR0, 1'b0);
                  emit(DEST_WIRE, {1'b0, pl_len[6:0]}, 1'b0);
               end
               if (pl_len == 0)
                  end_frame();
            end
         end
      end else begin
         k = int'(pl_cnt[1:0]);
         d = b ^ 8'(key >> (8 * (3 - k)));
         if (f_op == OP_CONT || f_op == OP_BINARY) begin
            emit(DEST_APP, d, 1'b0);
         end else if (f_op == OP_PING) begin
            emit(DEST_WIRE, d, 1'b0);
         end else if (f_op == OP_CLOSE) begin
            if (pl_cnt == 0)
               peer_code[15:8] = d;
            else if (pl_cnt == 1)
               peer_code[7:0] = d;
         end
         pl_cnt = pl_cnt + 63'd1;
         if (pl_cnt >= pl_len)
            end_frame();
      end
      if (step_cnt > 0)
         step_res[step_cnt - 1].last = 1'b1;
   endfunction

   // predict on every accepted request, then check every accepted response
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         req_taken++;
         deframe_byte(req_rx_byte);
         if (cur_typed) begin
            if (cur_cnt > 0)
               pending_out.insert(pending_out.size(), cur_r0);
            if (cur_cnt > 1)
               pending_out.insert(pending_out.size(), cur_r1);
         end else begin
            for (int i = 0; i < step_cnt; i++)
               pending_out.insert(pending_out.size(), step_res[i]);
         end
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         got_rsp = mk_rsp(rsp_dest, rsp_data_byte, rsp_last, rsp_conn_closed);
         if (pending_out.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected response: dest=%0d data=%02h last=%0d closed=%0d",
                        got_rsp.dest, got_rsp.data, got_rsp.last, got_rsp.closed);
         end else begin
            want_rsp = pending_out.pop_front();
            rsp_checked++;
            if (got_rsp.dest !== want_rsp.dest || got_rsp.data !== want_rsp.data ||
                got_rsp.last !== want_rsp.last || got_rsp.closed !== want_rsp.closed) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"mismatch: expected dest=%0d data=%02h last=%0d closed=%0d,",
                            " got dest=%0d data=%02h last=%0d closed=%0d"},
                           want_rsp.dest, want_rsp.data, want_rsp.last, want_rsp.closed,
                           got_rsp.dest, got_rsp.data, got_rsp.last, got_rsp.closed);
            end
         end
      end
   end

   // receiver stalls at random outside the quiet stretch
   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 19);
   end

   // one request byte, with random gaps before it
   task automatic send_req(input logic [7:0] b);
      while (!quiet && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do
         @(posedge clock);
      while (req_stall);
      @(negedge clock);
   endtask

   // hold the sender off until every expected response is out
   task automatic wait_drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_out.size() != 0)
         @(negedge clock);
   endtask

   function automatic void add_row(logic [7:0] rx, logic typed, logic [1:0] cnt,
                                   deframe_rsp_type r0, deframe_rsp_type r1);
      directed_rows.insert(directed_rows.size(), {typed, cnt, rx, r0, r1});
   endfunction

   // full masked frame with random key and payload
   task automatic send_frame(input logic [3:0] op, input logic fin, input logic [31:0] len,
                             input logic [1:0] form);
      send_req({fin, 3'b000, op});
      if (form == FORM_7) begin
         send_req({1'b1, len[6:0]});
      end else if (form == FORM_16) begin
         send_req({1'b1, LEN_16_CODE});
         send_req(len[15:8]);
         send_req(len[7:0]);
      end else begin
         send_req({1'b1, LEN_64_CODE});
         repeat (4) send_req(8'h00);
         send_req(len[31:24]);
         send_req(len[23:16]);
         send_req(len[15:8]);
         send_req(len[7:0]);
      end
      repeat (4) send_req(8'($urandom));
      for (int i = 0; i < int'(len); i++)
         send_req(8'($urandom));
      frames_sent++;
   endtask

   // well-formed data or control frame of random size and encoding
   task automatic send_random_frame();
      int          sel;
      int          r;
      logic [3:0]  op;
      logic        fin;
      logic [31:0] len;
      logic [1:0]  form;
      sel = $urandom_range(0, 99);
      r = $urandom_range(0, 99);
      fin = 1'b1;
      if (sel < 60) begin
         op = (sel < 40) ? OP_BINARY : OP_CONT;
         fin = 1'($urandom);
         if (r < 70) begin
            len = $urandom_range(0, 8);
            form = FORM_7;
         end else if (r < 80) begin
            len = $urandom_range(9, 125);
            form = FORM_7;
         end else if (r < 90) begin
            len = $urandom_range(0, 40);
            form = FORM_16;
         end else if (r < 95) begin
            len = $urandom_range(126, 300);
            form = FORM_16;
         end else begin
            len = $urandom_range(0, 20);
            form = FORM_64;
         end
      end else begin
         op = (sel < 80) ? OP_PING : OP_PONG;
         if (r < 80) begin
            len = $urandom_range(0, 8);
            form = FORM_7;
         end else if (r < 90) begin
            len = $urandom_range(0, 125);
            form = FORM_7;
         end else if (r < 95) begin
            len = $urandom_range(0, 125);
            form = FORM_16;
         end else begin
            len = $urandom_range(0, 125);
            form = FORM_64;
         end
      end
      send_frame(op, fin, len, form);
   endtask

   // one of the ways the connection ends
   task automatic send_closing_sequence();
      int         sel;
      logic [3:0] op;
      sel = $urandom_range(0, 8);
      case (sel)
         0: begin
            // reserved bits in the first header byte
            send_req({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)});
         end
         1: begin
            // unmasked client frame
            send_req({1'b1, 3'b000, OP_BINARY});
            send_req({1'b0, 7'($urandom)});
         end
         2: begin
            // 64-bit length with its top bit set
            send_req({1'b1, 3'b000, OP_BINARY});
            send_req({1'b1, LEN_64_CODE});
            send_req({1'b1, 7'($urandom)});
         end
         3: begin
            // fragmented control frame
            send_frame(4'($urandom_range(8, 15)), 1'b0, $urandom_range(0, 10), FORM_7);
         end
         4: begin
            // control frame longer than allowed
            send_frame(4'($urandom_range(8, 15)), 1'b1, $urandom_range(126, 140), FORM_16);
         end
         5: begin
            send_frame(OP_TEXT, 1'($urandom), $urandom_range(0, 10), FORM_7);
         end
         6: begin
            // reserved opcode, data or control range
            op = 4'($urandom_range(0, 9));
            op = (op < 5) ? op + 4'd3 : op + 4'd6;
            send_frame(op, 1'b1, $urandom_range(0, 10), FORM_7);
         end
         7: begin
            // peer close with a status code
            send_frame(OP_CLOSE, 1'b1, $urandom_range(2, 10), FORM_7);
         end
         default: begin
            // peer close without a status code
            send_frame(OP_CLOSE, 1'b1, $urandom_range(0, 1), FORM_7);
         end
      endcase
   endtask

   // stimulus and end of run
   initial begin
      bit pressure_done;
      pressure_done = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // binary frame, zero key, one extreme payload byte
      add_row({1'b1, 3'b000, OP_BINARY}, 1'b1, 2'd0, '0, '0);
      add_row({1'b1, 7'd1}, 1'b1, 2'd0, '0, '0);
      repeat (4) add_row(8'h00, 1'b1, 2'd0, '0, '0);
      add_row(8'hFF, 1'b1, 2'd1, mk_rsp(DEST_APP, 8'hFF, 1'b1, 1'b0), '0);
      // empty ping answered by an empty pong at the last key byte
      add_row({1'b1, 3'b000, OP_PING}, 1'b1, 2'd0, '0, '0);
      add_row({1'b1, 7'd0}, 1'b1, 2'd0, '0, '0);
      repeat (3) add_row(8'h00, 1'b1, 2'd0, '0, '0);
      add_row(8'h00, 1'b1, 2'd2, mk_rsp(DEST_WIRE, PONG_HDR0, 1'b0, 1'b0),
              mk_rsp(DEST_WIRE, 8'h00, 1'b1, 1'b0));
      // non-final continuation with a non-minimal 16-bit length
      add_row({1'b0, 3'b000, OP_CONT}, 1'b1, 2'd0, '0, '0);
      add_row({1'b1, LEN_16_CODE}, 1'b0, 2'd0, '0, '0);
      add_row(8'h00, 1'b0, 2'd0, '0, '0);
      add_row(8'h01, 1'b0, 2'd0, '0, '0);
      repeat (4) add_row(8'($urandom), 1'b0, 2'd0, '0, '0);
      add_row(8'h00, 1'b0, 2'd0, '0, '0);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         cur_typed = row.typed;
         cur_cnt = row.cnt;
         cur_r0 = row.r0;
         cur_r1 = row.r1;
         send_req(row.rx);
      end
      cur_typed = 1'b0;
      frames_sent += 3;
      wait_drain();

      // random well-formed traffic, with a stretch of full throughput
      while (req_taken < 520) begin
         quiet = (req_taken >= 200 && req_taken < 330);
         if (!pressure_done && req_taken >= 380) begin
            wait_drain();
            pressure_done = 1'b1;
         end
         send_random_frame();
      end
      quiet = 1'b0;

      send_closing_sequence();
      // everything after the close is dropped
      repeat (6) send_req(8'($urandom));

      wait_drain();
      repeat (20) @(negedge clock);
      fail_count += pending_out.size();
      $display("run covered %0d request bytes in %0d frames, %0d responses checked",
               req_taken, frames_sent, rsp_checked);
      $display("connection ended with close code %0d", close_code_sent);
      if (fail_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
